// ===== hw/rtl/srh_pkg.sv =====
// ----------------------------------------------------------------------------
// srh_pkg: shared types and constants for the sync-referenced histogram
// Holds the controller states, result kind codes, register indexes and the
// bin divider result bundle.
// ----------------------------------------------------------------------------
package srh_pkg;

  // Quotient bits produced by the bin divider (bin index field width)
  localparam int QUOT_W = 5;

  // Only events from this trigger source are classified
  localparam logic [2:0] TRIG_ACCEPTED = 3'd7;

  // Result kind codes
  localparam logic [1:0] KIND_DET = 2'd0;
  localparam logic [1:0] KIND_MON = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_BIN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_DET_CHAN   = 3'd1;
  localparam logic [2:0] CFG_SYNC_CHAN  = 3'd2;
  localparam logic [2:0] CFG_SEM_CHAN   = 3'd3;
  localparam logic [2:0] CFG_MON_CHAN   = 3'd4;
  localparam logic [2:0] CFG_MON_ENABLE = 3'd5;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CLASS,
    ST_DIV,
    ST_WR,
    ST_ERR,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  // Bin divider result: done pulses once, hit means quotient below 32
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

// ===== hw/rtl/sync_referenced_event_histogram.sv =====
// Flow: one item at a time; in_stall stays high from the accept until the item
//   is done, including out stalls. A dump reads each bin, then outputs it.
// Reset: registers to defaults, stores read as empty through per-bin valid
//   bits, so no clearing pass; the block takes items right after reset.
// ----------------------------------------------------------------------------
// sync_referenced_event_histogram: time-of-flight histogram scaler
// Bins detector and monitor events by time since the last sync event into two
// count memories; a semaphore event streams out both (monitor only when enabled) and clears both.
// ----------------------------------------------------------------------------
module sync_referenced_event_histogram #(
  parameter int NUM_BINS    = 32,
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write_en,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  // event input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_WIDTH-1:0] timestamp,
  input  logic [2:0]            trigger_id,
  input  logic [2:0]            channel,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [4:0]            bin_index,
  output logic [31:0]           bin_count
  ,
  output logic                  last
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  // configuration registers
  logic [31:0] bin_width;
  logic [2:0]  det_chan;
  logic [2:0]  sync_chan;
  logic [2:0]  sem_chan;
  logic [2:0]  mon_chan;
  logic        mon_enable;

  // event state
  srh_pkg::state_t       state;
  srh_pkg::state_t       state_next;
  logic [TIME_WIDTH-1:0] ts_q;
  logic [2:0]            trig_q;
  logic [2:0]            chan_q;
  logic [TIME_WIDTH-1:0] offset;
  logic                  captured;
  logic [TIME_WIDTH-1:0] sync_time;
  logic [TIME_WIDTH-1:0] rel_q;
  logic                  use_mon;
  logic [BIN_W-1:0]      dump_idx;
  logic [BIN_W-1:0]      addr_q;

  // count stores
  logic [COUNT_WIDTH-1:0] det_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] mon_mem [NUM_BINS];
  logic [NUM_BINS-1:0]    det_vld;
  logic [NUM_BINS-1:0]    mon_vld;
  logic [COUNT_WIDTH-1:0] det_rd;
  logic [COUNT_WIDTH-1:0] mon_rd;
  logic                   det_rd_vld;
  logic                   mon_rd_vld;

  // control
  logic                   in_accept;
  logic                   out_free;
  logic                   early;
  logic                   is_det;
  logic                   is_mon;
  logic                   is_sync;
  logic                   is_sem;
  logic                   bin_hit;
  logic                   dump_end;
  logic                   dump_final;
  logic                   div_start;
  logic                   rd_en;
  logic [BIN_W-1:0]       rd_addr;
  logic                   wr_en;
  logic                   out_load;
  logic                   vld_clear;
  logic [1:0]             load_kind;
  logic                   load_cnt_en;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic [31:0]            cur_cnt32;
  logic [TIME_WIDTH-1:0]  since;
  srh_pkg::div_res_t      div_res;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width  <= 32'd1;
      det_chan   <= 3'd7;
      sync_chan  <= 3'd7;
      sem_chan   <= 3'd7;
      mon_chan   <= 3'd7;
      mon_enable <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        srh_pkg::CFG_BIN_WIDTH:  bin_width  <= cfg_data;
        srh_pkg::CFG_DET_CHAN:   det_chan   <= cfg_data[2:0];
        srh_pkg::CFG_SYNC_CHAN:  sync_chan  <= cfg_data[2:0];
        srh_pkg::CFG_SEM_CHAN:   sem_chan   <= cfg_data[2:0];
        srh_pkg::CFG_MON_CHAN:   mon_chan   <= cfg_data[2:0];
        srh_pkg::CFG_MON_ENABLE: mon_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // decode helpers; first channel match wins in detector, monitor, sync order
  assign early   = ts_q < offset;
  assign is_det  = chan_q == det_chan;
  assign is_mon  = !is_det && chan_q == mon_chan;
  assign is_sync = !is_det && !is_mon && chan_q == sync_chan;
  assign is_sem  = !is_det && !is_mon && !is_sync && chan_q == sem_chan;
  assign since   = rel_q - sync_time;
  assign bin_hit = div_res.hit && ({1'b0, div_res.quot} < 6'(NUM_BINS));
  assign dump_end   = dump_idx == BIN_W'(NUM_BINS - 1);
  assign dump_final = dump_end && (use_mon || !mon_enable);

  // bin divider
  srh_bin_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (since),
    .divisor  (bin_width),
    .res      (div_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srh_pkg::ST_IDLE: begin
        if (in_valid) state_next = srh_pkg::ST_EVAL;
      end
      srh_pkg::ST_EVAL: begin
        if (early) state_next = srh_pkg::ST_ERR;
        else if (trig_q != srh_pkg::TRIG_ACCEPTED) state_next = srh_pkg::ST_IDLE;
        else state_next = srh_pkg::ST_CLASS;
      end
      srh_pkg::ST_CLASS: begin
        if (is_det || is_mon) state_next = srh_pkg::ST_DIV;
        else if (is_sem) state_next = srh_pkg::ST_DUMP_RD;
        else state_next = srh_pkg::ST_IDLE;
      end
      srh_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = bin_hit ? srh_pkg::ST_WR : srh_pkg::ST_IDLE;
        end
      end
      srh_pkg::ST_WR: state_next = srh_pkg::ST_IDLE;
      srh_pkg::ST_ERR: begin
        if (out_free) state_next = srh_pkg::ST_IDLE;
      end
      srh_pkg::ST_DUMP_RD: state_next = srh_pkg::ST_DUMP_OUT;
      srh_pkg::ST_DUMP_OUT: begin
        if (out_free) begin
          state_next = dump_final ? srh_pkg::ST_IDLE : srh_pkg::ST_DUMP_RD;
        end
      end
      default: state_next = srh_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall    = 1'b1;
    div_start   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = dump_idx;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    vld_clear   = 1'b0;
    load_kind   = srh_pkg::KIND_ERR;
    load_cnt_en = 1'b0;
    case (state)
      srh_pkg::ST_IDLE:  in_stall = 1'b0;
      srh_pkg::ST_CLASS: div_start = is_det || is_mon;
      srh_pkg::ST_DIV: begin
        rd_en   = div_res.done && bin_hit;
        rd_addr = div_res.quot[BIN_W-1:0];
      end
      srh_pkg::ST_WR:  wr_en = 1'b1;
      srh_pkg::ST_ERR: out_load = out_free;
      srh_pkg::ST_DUMP_RD: rd_en = 1'b1;
      srh_pkg::ST_DUMP_OUT: begin
        out_load    = out_free;
        vld_clear   = out_free && dump_final;
        load_kind   = use_mon ? srh_pkg::KIND_MON : srh_pkg::KIND_DET;
        load_cnt_en = 1'b1;
      end
      default: ;
    endcase
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srh_pkg::ST_IDLE;
      captured  <= 1'b0;
      offset    <= '0;
      sync_time <= '0;
    end else begin
      state <= state_next;
      // first item fixes the start offset
      if (in_accept && !captured) begin
        captured <= 1'b1;
        offset   <= timestamp;
      end
      if (state == srh_pkg::ST_CLASS && is_sync) begin
        sync_time <= rel_q;
      end
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ts_q   <= timestamp;
      trig_q <= trigger_id;
      chan_q <= channel;
    end
    if (state == srh_pkg::ST_EVAL) begin
      rel_q <= ts_q - offset;
    end
    if (state == srh_pkg::ST_CLASS) begin
      use_mon  <= is_mon;
      dump_idx <= '0;
    end
    if (state == srh_pkg::ST_DUMP_OUT && out_free && !dump_final) begin
      if (dump_end) begin
        use_mon  <= 1'b1;
        dump_idx <= '0;
      end else begin
        dump_idx <= dump_idx + BIN_W'(1);
      end
    end
    if (rd_en) begin
      addr_q <= rd_addr;
    end
  end

  // count memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (rd_en) begin
      det_rd     <= det_mem[rd_addr];
      mon_rd     <= mon_mem[rd_addr];
      det_rd_vld <= det_vld[rd_addr];
      mon_rd_vld <= mon_vld[rd_addr];
    end
    if (wr_en && !use_mon) begin
      det_mem[addr_q] <= inc_cnt;
    end
    if (wr_en && use_mon) begin
      mon_mem[addr_q] <= inc_cnt;
    end
  end

  // per-bin valid bits: an unwritten bin reads as zero
  always_ff @(posedge clk) begin
    if (rst || vld_clear) begin
      det_vld <= '0;
      mon_vld <= '0;
    end else if (wr_en) begin
      if (use_mon) mon_vld[addr_q] <= 1'b1;
      else det_vld[addr_q] <= 1'b1;
    end
  end

  // current count and saturating increment
  always_comb begin
    if (use_mon) cur_cnt = mon_rd_vld ? mon_rd : '0;
    else cur_cnt = det_rd_vld ? det_rd : '0;
    inc_cnt = (cur_cnt == CMAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
  end

  // clamp the reported count to 32 bits
  generate
    if (COUNT_WIDTH > 32) begin : g_clamp
      assign cur_cnt32 = (|cur_cnt[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cur_cnt[31:0];
    end else begin : g_extend
      assign cur_cnt32 = 32'(cur_cnt);
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind      <= load_kind;
      bin_index <= load_cnt_en ? 5'(dump_idx) : 5'd0;
      bin_count <= load_cnt_en ? cur_cnt32 : 32'd0;
      last      <= load_cnt_en ? dump_final : 1'b1;
    end
  end

  // checks
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == srh_pkg::ST_DIV)
    else $error("divider finished outside its wait state");

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == srh_pkg::KIND_ERR) |-> (bin_index == 5'd0 && bin_count == 32'd0 && last))
    else $error("error item carries bin data");

  a_dump_clears: assert property (@(posedge clk) disable iff (rst)
    vld_clear |=> (det_vld == '0 && mon_vld == '0))
    else $error("stores not empty after dump");

  a_offset_kept: assert property (@(posedge clk) disable iff (rst)
    captured |=> (captured && $stable(offset)))
    else $error("start offset changed after capture");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("item accepted while previous one in flight");

endmodule

// ===== hw/rtl/srh_bin_div.sv =====
// ----------------------------------------------------------------------------
// srh_bin_div: bin number divider
// Restoring division of the time since sync by the bin width, one quotient
// bit per cycle. A range check first drops quotients of 32 or more and a
// zero bin width, so only five steps are needed.
// ----------------------------------------------------------------------------
module srh_bin_div #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] dividend,
  input  logic [31:0]           divisor,
  output srh_pkg::div_res_t     res
);

  localparam int SHW = 32 + srh_pkg::QUOT_W;
  localparam int DW  = (TIME_WIDTH > SHW) ? TIME_WIDTH : SHW;
  localparam int STW = $clog2(srh_pkg::QUOT_W + 1);

  logic                      busy;
  logic                      checking;
  logic                      done;
  logic                      hit;
  logic [STW-1:0]            step;
  logic [DW-1:0]             rem;
  logic [SHW-1:0]            dsh;
  logic [srh_pkg::QUOT_W-1:0] quot;
  logic                      ge;

  // trial compare against the current shifted divisor
  assign ge = (rem >= DW'(dsh));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (checking) begin
          if (dsh == '0 || ge) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else if (step == STW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      checking <= 1'b1;
      rem      <= DW'(dividend);
      dsh      <= {divisor, {srh_pkg::QUOT_W{1'b0}}};
      quot     <= '0;
      step     <= STW'(srh_pkg::QUOT_W);
      hit      <= 1'b0;
    end else if (busy) begin
      dsh <= dsh >> 1;
      if (checking) begin
        // quotient of 32 or more, or zero width: out of range
        checking <= 1'b0;
        hit      <= !(dsh == '0 || ge);
      end else begin
        if (ge) begin
          rem <= rem - DW'(dsh);
        end
        quot <= {quot[srh_pkg::QUOT_W-2:0], ge};
        step <= step - STW'(1);
      end
    end
  end

  assign res.done = done;
  assign res.hit  = hit;
  assign res.quot = quot;

endmodule
